[rtl/core/tsfc_pkg.sv]
// Shared types and constants for the touch sample filter and calibration block.
package tsfc_pkg;

  localparam int DataW    = 16;
  localparam int CfgW     = 17;
  localparam int CfgIdxW  = 3;
  localparam int SensW    = 3;
  localparam int FiltW    = 17;
  localparam int PressW   = 30;
  localparam int ProdW    = 34;
  localparam int DivSteps = 30;
  localparam int DivCntW  = 5;
  localparam int PressShift = 14;
  localparam int CalShift   = 15;
  localparam int LpfShift   = 4;
  localparam int JumpLimit  = 1000;
  localparam int SensMax    = 4;
  localparam int SensReset  = 2;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_PRESS   = 2'd1,
    EV_MOVE    = 2'd2,
    EV_RELEASE = 2'd3
  } event_kind_e;

  typedef enum logic [2:0] {
    REG_SENSITIVITY = 3'd0,
    REG_X_OFFSET    = 3'd1,
    REG_X_SCALE     = 3'd2,
    REG_Y_OFFSET    = 3'd3,
    REG_Y_SCALE     = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MUL_PRESS = 2'd0,
    MUL_X     = 2'd1,
    MUL_Y     = 2'd2
  } mul_sel_e;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     div_init;
    logic     div_step;
    logic     decide;
    logic     cal_x;
    logic     cal_y;
    logic     finish;
  } cmd_t;

  typedef struct packed {
    logic pen;
    logic div_ok;
    logic pressed;
  } sts_t;

endpackage

[rtl/core/tsfc_ctrl.sv]
// Sequencing state machine for the touch sample filter and calibration block.
module tsfc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  tsfc_pkg::sts_t sts_i,
  output tsfc_pkg::cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_P,
    S_CHECK,
    S_DIV,
    S_DECIDE,
    S_MUL_X,
    S_CAL_X,
    S_MUL_Y,
    S_CAL_Y,
    S_FINISH
  } state_e;

  state_e                        state_q;
  logic [tsfc_pkg::DivCntW-1:0]  cnt_q;
  logic                          out_valid_q;
  logic                          out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o = '0;
    cmd_o.mul_sel = tsfc_pkg::MUL_PRESS;
    case (state_q)
      S_IDLE:   cmd_o.load = in_valid_i;
      S_MUL_P: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = tsfc_pkg::MUL_PRESS;
      end
      S_CHECK:  cmd_o.div_init = sts_i.pen && sts_i.div_ok;
      S_DIV:    cmd_o.div_step = 1'b1;
      S_DECIDE: cmd_o.decide = 1'b1;
      S_MUL_X: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = tsfc_pkg::MUL_X;
      end
      S_CAL_X:  cmd_o.cal_x = 1'b1;
      S_MUL_Y: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = tsfc_pkg::MUL_Y;
      end
      S_CAL_Y:  cmd_o.cal_y = 1'b1;
      S_FINISH: cmd_o.finish = out_free;
      default:  cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_MUL_P;
          end
        end
        S_MUL_P:  state_q <= S_CHECK;
        S_CHECK: begin
          cnt_q <= '0;
          if (!sts_i.pen) begin
            state_q <= S_FINISH;
          end else if (sts_i.div_ok) begin
            state_q <= S_DIV;
          end else begin
            state_q <= S_DECIDE;
          end
        end
        S_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == tsfc_pkg::DivCntW'(tsfc_pkg::DivSteps - 1)) begin
            state_q <= S_DECIDE;
          end
        end
        S_DECIDE: state_q <= sts_i.pressed ? S_MUL_X : S_FINISH;
        S_MUL_X:  state_q <= S_CAL_X;
        S_CAL_X:  state_q <= S_MUL_Y;
        S_MUL_Y:  state_q <= S_CAL_Y;
        S_CAL_Y:  state_q <= S_FINISH;
        S_FINISH: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default:  state_q <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/tsfc_datapath.sv]
// Datapath: configuration, touch state, shared multiplier, divider and output register.
module tsfc_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tsfc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [tsfc_pkg::CfgW-1:0]     cfg_data_i,
  input  tsfc_pkg::cmd_t                cmd_i,
  output tsfc_pkg::sts_t                sts_o,
  input  logic                          pen_down_i,
  input  logic [tsfc_pkg::DataW-1:0]    x_raw_i,
  input  logic [tsfc_pkg::DataW-1:0]    y_raw_i,
  input  logic [tsfc_pkg::DataW-1:0]    z1_raw_i,
  input  logic [tsfc_pkg::DataW-1:0]    z2_raw_i,
  output logic [1:0]                    event_kind_o,
  output logic [tsfc_pkg::DataW-1:0]    pos_x_o,
  output logic [tsfc_pkg::DataW-1:0]    pos_y_o,
  output logic [tsfc_pkg::PressW-1:0]   pressure_level_o
);

  localparam int DW = tsfc_pkg::DataW;
  localparam int FW = tsfc_pkg::FiltW;
  localparam int PW = tsfc_pkg::PressW;
  localparam int MW = tsfc_pkg::ProdW;

  // Configuration and persistent touch state.
  logic [tsfc_pkg::SensW-1:0] sens_q;
  logic signed [DW-1:0]       x_off_q, y_off_q;
  logic signed [FW-1:0]       x_scale_q, y_scale_q;
  logic signed [DW-1:0]       coord_x_q, coord_y_q;
  logic signed [FW-1:0]       filt_x_q, filt_y_q;
  logic [PW-1:0]              press_q;

  // Working registers for the item in flight.
  logic                       pen_q;
  logic [DW-1:0]              x_q, y_q, z1_q, z2_q;
  logic signed [MW-1:0]       prod_q;
  logic [PW-1:0]              rem_q, quo_q;
  tsfc_pkg::event_kind_e      kind_q;

  // Output register.
  tsfc_pkg::event_kind_e      out_kind_q;
  logic [DW-1:0]              out_x_q, out_y_q;
  logic [PW-1:0]              out_press_q;

  logic signed [FW-1:0]       mul_a, mul_b;
  logic signed [MW-1:0]       mul_p;
  logic [PW-1:0]              trial;
  logic                       trial_ge;
  logic                       touched, div_ok, pressed, release_ev;
  logic signed [FW-1:0]       base_x, base_y, filt_x_d, filt_y_d;
  logic signed [FW:0]         dx, dy, dx_sel, dy_sel, dx_adj, dy_adj, dx_step, dy_step;
  logic                       jump;
  logic signed [MW-1:0]       cal_adj, cal_shift;
  logic signed [DW+3:0]       cal_sum;
  logic signed [DW-1:0]       cal_off, cal_sat;
  logic [tsfc_pkg::SensW-1:0] sens_wr;

  always_comb begin
    case (cmd_i.mul_sel)
      tsfc_pkg::MUL_PRESS: begin
        mul_a = $signed({{(FW-DW+tsfc_pkg::LpfShift){1'b0}}, x_q[DW-1:tsfc_pkg::LpfShift]});
        mul_b = $signed({1'b0, z2_q}) - $signed({1'b0, z1_q});
      end
      tsfc_pkg::MUL_X: begin
        mul_a = filt_x_q;
        mul_b = x_scale_q;
      end
      tsfc_pkg::MUL_Y: begin
        mul_a = filt_y_q;
        mul_b = y_scale_q;
      end
      default: begin
        mul_a = filt_x_q;
        mul_b = x_scale_q;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Restoring divider: one quotient bit per cycle, numerator shifted out of quo_q.
  assign trial    = {rem_q[PW-2:0], quo_q[PW-1]};
  assign trial_ge = (trial >= PW'(prod_q));

  assign div_ok  = !prod_q[MW-1] && (prod_q != '0);
  assign pressed = div_ok && (quo_q > PW'(sens_q));
  assign touched = !coord_x_q[DW-1];
  assign release_ev = !pen_q && touched;

  assign sts_o.pen     = pen_q;
  assign sts_o.div_ok  = div_ok;
  assign sts_o.pressed = pressed;

  // Low-pass filter step; a first touch seeds the filter with the raw sample.
  always_comb begin
    base_x = touched ? filt_x_q : $signed({1'b0, x_q});
    base_y = touched ? filt_y_q : $signed({1'b0, y_q});
    dx = $signed({2'b00, x_q}) - {base_x[FW-1], base_x};
    dy = $signed({2'b00, y_q}) - {base_y[FW-1], base_y};
    jump = (dx > (FW+1)'(tsfc_pkg::JumpLimit)) || (dx < -(FW+1)'(tsfc_pkg::JumpLimit)) ||
           (dy > (FW+1)'(tsfc_pkg::JumpLimit)) || (dy < -(FW+1)'(tsfc_pkg::JumpLimit));
    dx_sel = jump ? '0 : dx;
    dy_sel = jump ? '0 : dy;
    // Bias negative values so the shift truncates toward zero.
    dx_adj = dx_sel[FW] ? dx_sel + (FW+1)'((1 << tsfc_pkg::LpfShift) - 1) : dx_sel;
    dy_adj = dy_sel[FW] ? dy_sel + (FW+1)'((1 << tsfc_pkg::LpfShift) - 1) : dy_sel;
    dx_step = dx_adj >>> tsfc_pkg::LpfShift;
    dy_step = dy_adj >>> tsfc_pkg::LpfShift;
    filt_x_d = base_x + FW'(dx_step);
    filt_y_d = base_y + FW'(dy_step);
  end

  // Calibration: offset plus product over 32768, truncated toward zero, then saturated.
  always_comb begin
    cal_adj   = prod_q[MW-1] ? prod_q + MW'((1 << tsfc_pkg::CalShift) - 1) : prod_q;
    cal_shift = cal_adj >>> tsfc_pkg::CalShift;
    cal_off   = cmd_i.cal_x ? x_off_q : y_off_q;
    cal_sum   = (DW+4)'(cal_off) + (DW+4)'(cal_shift);
    if (cal_sum > (DW+4)'((1 << (DW-1)) - 1)) begin
      cal_sat = {1'b0, {(DW-1){1'b1}}};
    end else if (cal_sum < -(DW+4)'(1 << (DW-1))) begin
      cal_sat = {1'b1, {(DW-1){1'b0}}};
    end else begin
      cal_sat = cal_sum[DW-1:0];
    end
  end

  assign sens_wr = (cfg_data_i[tsfc_pkg::SensW-1:0] > tsfc_pkg::SensW'(tsfc_pkg::SensMax)) ?
                   tsfc_pkg::SensW'(tsfc_pkg::SensMax) : cfg_data_i[tsfc_pkg::SensW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sens_q    <= tsfc_pkg::SensW'(tsfc_pkg::SensReset);
      x_off_q   <= '0;
      x_scale_q <= '0;
      y_off_q   <= '0;
      y_scale_q <= '0;
      coord_x_q <= '1;
      coord_y_q <= '1;
      filt_x_q  <= '0;
      filt_y_q  <= '0;
      press_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          tsfc_pkg::REG_SENSITIVITY: sens_q    <= sens_wr;
          tsfc_pkg::REG_X_OFFSET:    x_off_q   <= cfg_data_i[DW-1:0];
          tsfc_pkg::REG_X_SCALE:     x_scale_q <= cfg_data_i;
          tsfc_pkg::REG_Y_OFFSET:    y_off_q   <= cfg_data_i[DW-1:0];
          tsfc_pkg::REG_Y_SCALE:     y_scale_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.decide) begin
        if (pressed) begin
          press_q  <= quo_q - PW'(sens_q);
          filt_x_q <= filt_x_d;
          filt_y_q <= filt_y_d;
        end else begin
          press_q <= '0;
        end
      end
      if (cmd_i.cal_x) begin
        coord_x_q <= cal_sat;
      end
      if (cmd_i.cal_y) begin
        coord_y_q <= cal_sat;
      end
      if (cmd_i.finish && release_ev) begin
        coord_x_q <= '1;
        coord_y_q <= '1;
        press_q   <= '0;
        filt_x_q  <= '0;
        filt_y_q  <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pen_q  <= pen_down_i;
      x_q    <= x_raw_i;
      y_q    <= y_raw_i;
      z1_q   <= z1_raw_i;
      z2_q   <= z2_raw_i;
      kind_q <= tsfc_pkg::EV_NONE;
    end
    if (cmd_i.mul_en) begin
      prod_q <= mul_p;
    end
    if (cmd_i.div_init) begin
      rem_q <= '0;
      quo_q <= {z1_q, {tsfc_pkg::PressShift{1'b0}}};
    end else if (cmd_i.div_step) begin
      rem_q <= trial_ge ? trial - PW'(prod_q) : trial;
      quo_q <= {quo_q[PW-2:0], trial_ge};
    end
    if (cmd_i.decide && pressed) begin
      kind_q <= touched ? tsfc_pkg::EV_MOVE : tsfc_pkg::EV_PRESS;
    end
    if (cmd_i.finish) begin
      out_kind_q  <= release_ev ? tsfc_pkg::EV_RELEASE : kind_q;
      out_x_q     <= coord_x_q;
      out_y_q     <= coord_y_q;
      out_press_q <= release_ev ? '0 : press_q;
    end
  end

  assign event_kind_o     = out_kind_q;
  assign pos_x_o          = out_x_q;
  assign pos_y_o          = out_y_q;
  assign pressure_level_o = out_press_q;

endmodule

[rtl/core/touch_sample_filter_calibrate.sv]
// Top level of the touch sample filter and calibration block.
// Path: a pen-up poll goes from the pressure product straight to the output register, a zero
// or negative pressure divisor skips the bit-serial divider, and a pressure not above the
// threshold skips the calibration. The block takes one poll at a time, the multiplier is
// shared, and a result awaiting its transfer holds the next poll at its end.
// Reset (asynchronous, active low) restores the default configuration and "not touched".
module touch_sample_filter_calibrate (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Poll input: tdata = x_raw[15:0], y_raw[31:16], z1_raw[47:32], z2_raw[63:48].
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,
  // tuser = pen_down[0].
  input  logic        s_axis_tuser,
  // Event output: tdata = pos_x[15:0], pos_y[31:16], pressure_level[61:32], zero[63:62].
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,
  // tuser = event_kind[1:0].
  output logic [1:0]  m_axis_tuser,
  // Configuration write port; register index follows the register list.
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [16:0] cfg_data_i
);

  tsfc_pkg::cmd_t cmd;
  tsfc_pkg::sts_t sts;

  logic [tsfc_pkg::DataW-1:0]  pos_x, pos_y;
  logic [tsfc_pkg::PressW-1:0] pressure_level;

  // The controller sequences one poll at a time: capture, pressure product, divider,
  // filter decision, two calibration products and the hand-over to the output register.
  tsfc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // The datapath holds the configuration, the filtered and calibrated touch state and
  // the output register, so a new poll may be taken while a result awaits its transfer.
  tsfc_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .pen_down_i       (s_axis_tuser),
    .x_raw_i          (s_axis_tdata[15:0]),
    .y_raw_i          (s_axis_tdata[31:16]),
    .z1_raw_i         (s_axis_tdata[47:32]),
    .z2_raw_i         (s_axis_tdata[63:48]),
    .event_kind_o     (m_axis_tuser),
    .pos_x_o          (pos_x),
    .pos_y_o          (pos_y),
    .pressure_level_o (pressure_level)
  );

  assign m_axis_tdata = {2'b00, pressure_level, pos_y, pos_x};

`ifndef SYNTH
  // Only one poll is in flight: after an input transfer the input side closes.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while a poll was still in flight");

  // A release always reports zero pressure.
  a_release_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == tsfc_pkg::EV_RELEASE) |-> (pressure_level == '0))
    else $error("release event carries non-zero pressure");

  // Press and move only follow a pressure strictly above the threshold.
  a_press_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && ((m_axis_tuser == tsfc_pkg::EV_PRESS) ||
                      (m_axis_tuser == tsfc_pkg::EV_MOVE)) |-> (pressure_level != '0))
    else $error("press or move event with zero pressure");
`endif

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for the touch sample filter and calibration block.
module tb;
  import tsfc_pkg::*;

  // Arithmetic constants of the pressure estimate, the low-pass step and the calibration.
  localparam int PressNum = 16384;
  localparam int LpfDiv   = 16;
  localparam int JumpMax  = 1000;
  localparam int CalDiv   = 32768;
  localparam int SensCap  = 4;
  localparam int SensInit = 2;

  // Run shape: the watchdog limit leaves a wide margin over the long receiver hold-off plus the
  // slowest poll and a full pipeline.
  localparam int ResetCycles  = 11;
  localparam int HoldCycles   = 600;
  localparam int StuckLimit   = 5000;
  localparam int MaxReports   = 10;
  localparam int Phases       = 8;
  localparam int PhaseItems   = 125;
  localparam int SettleCycles = 60;

  typedef enum logic {ROW_POLL, ROW_CFG} row_op_e;

  typedef struct packed {
    logic        pen;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z1;
    logic [15:0] z2;
  } poll_t;

  typedef struct packed {
    event_kind_e kind;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [29:0] pressure;
  } touch_event_t;

  // One line of the directed table: either a register write or a poll, the latter with
  // an optional hand-written expectation.
  typedef struct packed {
    row_op_e      op;
    cfg_reg_e     reg_idx;
    logic [16:0]  cfg_val;
    poll_t        poll;
    logic         typed;
    touch_event_t want;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // tdata = x_raw[15:0], y_raw[31:16], z1_raw[47:32], z2_raw[63:48].
  logic [63:0] s_axis_tdata = '0;
  // tuser = pen_down[0].
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // tdata = pos_x[15:0], pos_y[31:16], pressure_level[61:32], zero[63:62].
  logic [63:0] m_axis_tdata;
  // tuser = event_kind[1:0].
  logic [1:0]  m_axis_tuser;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_index_i = REG_SENSITIVITY;
  logic [16:0] cfg_data_i = '0;

  always #5 clk_i = ~clk_i;

  touch_sample_filter_calibrate dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Predictor copy of the configuration and the touch state, at their reset values.
  int          sens_lvl = SensInit;
  int          x_off = 0, x_gain = 0, y_off = 0, y_gain = 0;
  int          coord_x = -1, coord_y = -1;
  int          filt_x = 0, filt_y = 0;
  logic [29:0] held_pressure = '0;

  touch_event_t expected_events[$];
  row_t         directed[$];
  int           mismatches = 0;
  int           results_seen = 0;
  int           polls_sent = 0;
  int           settings_used = 1;
  int           burst_left = 0;
  int           kind_count [4] = '{default: 0};

  // Handshake between the stimulus and the receiver for the long hold-off: the stimulus
  // bumps the request count and the receiver notices the change.
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int stall_pct = 0;
  int mode_left = 0;
  int stuck_cycles = 0;

  // Calibration of one axis: offset plus a truncated fractional gain, clipped to 16 bits.
  function automatic int calibrate_axis(int off, int gain, int f);
    longint t;
    t = longint'(off) + (longint'(f) * longint'(gain)) / CalDiv;
    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;
    return int'(t);
  endfunction

  // Works out the event for one poll and advances the predicted touch state.
  function automatic touch_event_t predict_poll(poll_t p);
    touch_event_t ev;
    int           xr, yr, z1, z2, dx, dy;
    longint       divisor, force_est;
    logic         pressed;
    xr = p.x;
    yr = p.y;
    z1 = p.z1;
    z2 = p.z2;
    ev.kind = EV_NONE;
    if (p.pen) begin
      divisor = longint'(xr / LpfDiv) * longint'(z2 - z1);
      force_est = 0;
      pressed = 1'b0;
      if (divisor != 0) begin
        force_est = (longint'(PressNum) * longint'(z1)) / divisor;
        pressed = force_est > longint'(sens_lvl);
      end
      if (pressed) begin
        held_pressure = 30'(force_est - longint'(sens_lvl));
        ev.kind = EV_MOVE;
        // A negative calibrated x also counts as untouched, so the filter is reseeded.
        if (coord_x < 0) begin
          ev.kind = EV_PRESS;
          filt_x = xr;
          filt_y = yr;
        end
        dx = xr - filt_x;
        dy = yr - filt_y;
        if (dx > JumpMax || dx < -JumpMax || dy > JumpMax || dy < -JumpMax) begin
          dx = 0;
          dy = 0;
        end
        filt_x += dx / LpfDiv;
        filt_y += dy / LpfDiv;
        coord_x = calibrate_axis(x_off, x_gain, filt_x);
        coord_y = calibrate_axis(y_off, y_gain, filt_y);
      end else begin
        held_pressure = '0;
      end
      ev.pos_x = 16'(coord_x);
      ev.pos_y = 16'(coord_y);
      ev.pressure = held_pressure;
    end else if (coord_x >= 0) begin
      ev.kind = EV_RELEASE;
      ev.pos_x = 16'(coord_x);
      ev.pos_y = 16'(coord_y);
      ev.pressure = '0;
      coord_x = -1;
      coord_y = -1;
      held_pressure = '0;
      filt_x = 0;
      filt_y = 0;
    end else begin
      ev.pos_x = 16'(coord_x);
      ev.pos_y = 16'(coord_y);
      ev.pressure = held_pressure;
    end
    return ev;
  endfunction

  function automatic row_t poll_row(logic pen, int x, int y, int z1, int z2);
    row_t r;
    r = '0;
    r.op = ROW_POLL;
    r.poll = '{pen, 16'(x), 16'(y), 16'(z1), 16'(z2)};
    return r;
  endfunction

  function automatic row_t chk_row(logic pen, int x, int y, int z1, int z2,
                                   event_kind_e k, int px, int py, int pr);
    row_t r;
    r = poll_row(pen, x, y, z1, z2);
    r.typed = 1'b1;
    r.want = '{k, 16'(px), 16'(py), 30'(pr)};
    return r;
  endfunction

  function automatic row_t cfg_row(cfg_reg_e idx, int v);
    row_t r;
    r = '0;
    r.op = ROW_CFG;
    r.reg_idx = idx;
    r.cfg_val = 17'(v);
    return r;
  endfunction

  // Moves a coordinate by a random step of up to reach, clipped to the converter range.
  function automatic logic [15:0] wander(logic [15:0] base, int reach);
    int v;
    v = int'(base) + int'($urandom_range(0, 2 * reach)) - reach;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return 16'(v);
  endfunction

  // Writes one register on the edge that follows; the caller lowers the enable after a batch.
  task automatic program_reg(cfg_reg_e idx, logic [16:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      REG_SENSITIVITY: sens_lvl = (val[2:0] > SensCap) ? SensCap : int'(val[2:0]);
      REG_X_OFFSET:    x_off = int'($signed(val[15:0]));
      REG_X_SCALE:     x_gain = int'($signed(val));
      REG_Y_OFFSET:    y_off = int'($signed(val[15:0]));
      REG_Y_SCALE:     y_gain = int'($signed(val));
      default: ;
    endcase
  endtask

  // Offers one poll, in bursts separated by random gaps, and files its expected event once
  // the transfer has happened.
  task automatic send_poll(poll_t p, logic typed, touch_event_t want);
    int           gap;
    touch_event_t pred;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {p.z2, p.z1, p.y, p.x};
    s_axis_tuser <= p.pen;
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
    polls_sent++;
    pred = predict_poll(p);
    expected_events.push_back(typed ? want : pred);
  endtask

  // Stops offering and waits until every filed event has come back, then lets the block
  // settle so that a register write finds it idle.
  task automatic wait_all_events();
    s_axis_tvalid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // A pen stroke: jittering position with the odd large jump, pressure around the
  // threshold, a few degenerate divisors, and usually a pen-up at the end.
  task automatic run_stroke();
    int    len, reach;
    poll_t p;
    len = $urandom_range(1, 24);
    p.pen = 1'b1;
    p.x = 16'($urandom);
    p.y = 16'($urandom);
    for (int i = 0; i < len; i++) begin
      reach = ($urandom_range(0, 11) == 0) ? 3000 : 60;
      p.x = wander(p.x, reach);
      p.y = wander(p.y, reach);
      p.z1 = 16'($urandom_range(0, 4000));
      p.z2 = 16'(int'(p.z1) + int'($urandom_range(1, 3000)));
      case ($urandom_range(0, 15))
        0: p.z2 = p.z1;
        1: p.x = 16'($urandom_range(0, 15));
        2: p.z2 = 16'($urandom_range(0, p.z1));
        3: begin
          p.z1 = 16'($urandom);
          p.z2 = 16'($urandom);
        end
        default: ;
      endcase
      send_poll(p, 1'b0, '0);
    end
    if ($urandom_range(0, 4) != 0) begin
      p = '{1'b0, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
      send_poll(p, 1'b0, '0);
    end
  endtask

  // Unstructured polls with every field fully random.
  task automatic run_noise();
    int    n;
    poll_t p;
    n = $urandom_range(1, 4);
    repeat (n) begin
      p = '{1'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
      send_poll(p, 1'b0, '0);
    end
  endtask

  // Picks the calibration for a phase: unity gain, all maxima, minimum offsets and gains, then random.
  task automatic choose_setting(int ph);
    logic [16:0] sens, xo, xg, yo, yg;
    case (ph)
      0: begin
        sens = 17'd0;
        xo = 17'd0;
        yo = 17'd0;
        xg = 17'd32768;
        yg = 17'd32768;
      end
      1: begin
        sens = 17'd7;
        xo = 17'(32767);
        yo = 17'(32767);
        xg = 17'(65535);
        yg = 17'(65535);
      end
      2: begin
        sens = 17'd4;
        xo = 17'(-32768);
        yo = 17'(-32768);
        xg = 17'(-65536);
        yg = 17'(-65536);
      end
      default: begin
        sens = 17'($urandom_range(0, 7));
        xo = 17'($urandom);
        yo = 17'($urandom);
        xg = $urandom_range(0, 1) ? 17'($urandom) : 17'($urandom_range(28768, 36768));
        yg = $urandom_range(0, 1) ? 17'($urandom) : 17'($urandom_range(28768, 36768));
      end
    endcase
    program_reg(REG_SENSITIVITY, sens);
    program_reg(REG_X_OFFSET, xo);
    program_reg(REG_X_SCALE, xg);
    program_reg(REG_Y_OFFSET, yo);
    program_reg(REG_Y_SCALE, yg);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  // Receiver: stalls with a probability that is redrawn at random intervals, including
  // stretches with no stalls at all, and holds off completely when asked to.
  always @(posedge clk_i) begin
    if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HoldCycles;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        mode_left <= $urandom_range(16, 200);
        case ($urandom_range(0, 4))
          0, 1: stall_pct <= 0;
          2: stall_pct <= 30;
          3: stall_pct <= 60;
          default: stall_pct <= 90;
        endcase
      end else begin
        mode_left <= mode_left - 1;
      end
      m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Event checker: each transfer on the output is compared with the oldest expectation.
  always @(posedge clk_i) begin : check_events
    touch_event_t want, got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.kind = event_kind_e'(m_axis_tuser);
      got.pos_x = m_axis_tdata[15:0];
      got.pos_y = m_axis_tdata[31:16];
      got.pressure = m_axis_tdata[61:32];
      results_seen++;
      kind_count[got.kind]++;
      if (expected_events.size() == 0) begin
        if (mismatches < MaxReports)
          $display("[%0t] event with nothing pending: kind %0d x %0d y %0d p %0d", $realtime,
                   got.kind, $signed(got.pos_x), $signed(got.pos_y), got.pressure);
        mismatches++;
      end else begin
        want = expected_events.pop_front();
        if (want !== got || m_axis_tdata[63:62] !== 2'b00) begin
          if (mismatches < MaxReports)
            $display({"[%0t] event %0d: expected kind %0d x %0d y %0d p %0d, ",
                      "got kind %0d x %0d y %0d p %0d pad %0d"},
                     $realtime, results_seen, want.kind, $signed(want.pos_x),
                     $signed(want.pos_y), want.pressure, got.kind, $signed(got.pos_x),
                     $signed(got.pos_y), got.pressure, m_axis_tdata[63:62]);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: ends the run when neither side has moved a transfer for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles == StuckLimit) begin
      $display("[%0t] no transfer for %0d cycles, giving up", $realtime, StuckLimit);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : stimulus
    int start;
    int pick;
    logic cfg_open;

    // Directed table. Under the reset calibration every gain is zero, so a touched position
    // reads as the offset, zero, and the expected events can be written down directly.
    directed.push_back(chk_row(1'b0, 0, 0, 0, 0, EV_NONE, -1, -1, 0));
    // Degenerate divisors: x below one sixteenth step, then equal z words.
    directed.push_back(chk_row(1'b1, 15, 500, 100, 200, EV_NONE, -1, -1, 0));
    directed.push_back(chk_row(1'b1, 4096, 4096, 500, 500, EV_NONE, -1, -1, 0));
    directed.push_back(chk_row(1'b1, 16, 0, 1, 2, EV_PRESS, 0, 0, 16382));
    // Largest pressure the fields can produce.
    directed.push_back(chk_row(1'b1, 16, 0, 65534, 65535, EV_MOVE, 0, 0, 1073709054));
    // Pressure exactly at the threshold, then one above it.
    directed.push_back(chk_row(1'b1, 16, 0, 1, 8193, EV_NONE, 0, 0, 0));
    directed.push_back(chk_row(1'b1, 16, 0, 1, 5462, EV_MOVE, 0, 0, 1));
    // A negative divisor reads as no press.
    directed.push_back(chk_row(1'b1, 65535, 65535, 2, 1, EV_NONE, 0, 0, 0));
    directed.push_back(chk_row(1'b0, 0, 0, 0, 0, EV_RELEASE, 0, 0, 0));
    directed.push_back(chk_row(1'b0, 65535, 65535, 65535, 65535, EV_NONE, -1, -1, 0));
    directed.push_back(chk_row(1'b1, 65535, 65535, 1, 2, EV_PRESS, 0, 0, 2));
    directed.push_back(chk_row(1'b1, 65535, 0, 0, 65535, EV_NONE, 0, 0, 0));
    directed.push_back(chk_row(1'b0, 0, 0, 0, 0, EV_RELEASE, 0, 0, 0));
    // Sensitivity above the cap, unity-ish x gain and a doubling y gain.
    directed.push_back(cfg_row(REG_SENSITIVITY, 7));
    directed.push_back(cfg_row(REG_X_OFFSET, 100));
    directed.push_back(cfg_row(REG_X_SCALE, 32768));
    directed.push_back(cfg_row(REG_Y_OFFSET, -50));
    directed.push_back(cfg_row(REG_Y_SCALE, 65535));
    directed.push_back(chk_row(1'b1, 16, 0, 1, 5462, EV_NONE, -1, -1, 0));
    directed.push_back(poll_row(1'b1, 1000, 2000, 1000, 1100));
    directed.push_back(poll_row(1'b1, 1040, 2016, 1000, 1100));
    // Jumps beyond the limit on x and then on y are ignored by the filter.
    directed.push_back(poll_row(1'b1, 2100, 2000, 1000, 1100));
    directed.push_back(poll_row(1'b1, 1000, 30000, 1000, 1100));
    directed.push_back(poll_row(1'b0, 0, 0, 0, 0));
    // Large y with a doubling gain saturates high.
    directed.push_back(poll_row(1'b1, 500, 40000, 1000, 1100));
    // Most negative offset and gain drive x below zero, which reads as untouched.
    directed.push_back(cfg_row(REG_X_OFFSET, -32768));
    directed.push_back(cfg_row(REG_X_SCALE, -65536));
    directed.push_back(poll_row(1'b1, 500, 40000, 1000, 1100));
    directed.push_back(poll_row(1'b1, 510, 40000, 1000, 1100));
    directed.push_back(poll_row(1'b0, 0, 0, 0, 0));
    directed.push_back(poll_row(1'b0, 0, 0, 0, 0));

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    cfg_open = 1'b0;
    for (int i = 0; i < directed.size(); i++) begin
      if (directed[i].op == ROW_CFG) begin
        if (!cfg_open) wait_all_events();
        program_reg(directed[i].reg_idx, directed[i].cfg_val);
        cfg_open = 1'b1;
      end else begin
        if (cfg_open) begin
          cfg_we_i <= 1'b0;
          cfg_open = 1'b0;
        end
        send_poll(directed[i].poll, directed[i].typed, directed[i].want);
      end
    end

    // Random phases, each under its own calibration. Two of them start with a long receiver
    // hold-off while polls keep coming, so the block backs up into its input.
    for (int ph = 0; ph < Phases; ph++) begin
      wait_all_events();
      choose_setting(ph);
      if (ph == 2 || ph == 5) hold_req++;
      start = polls_sent;
      while (polls_sent - start < PhaseItems) begin
        pick = $urandom_range(0, 19);
        if (pick < 14) run_stroke();
        else if (pick < 19) run_noise();
        else wait_all_events();
      end
    end

    wait_all_events();
    repeat (SettleCycles) @(posedge clk_i);

    $display("Run covered %0d polls under %0d calibration settings; %0d events checked.",
             polls_sent, settings_used, results_seen);
    $display("Events: %0d none, %0d press, %0d move, %0d release; %0d mismatches.",
             kind_count[EV_NONE], kind_count[EV_PRESS], kind_count[EV_MOVE],
             kind_count[EV_RELEASE], mismatches);
    if (mismatches == 0 && expected_events.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/tsfc_pkg.sv
rtl/core/tsfc_ctrl.sv
rtl/core/tsfc_datapath.sv
rtl/core/touch_sample_filter_calibrate.sv
tb/sv/tb.sv
